/* rtl/core/bfrv_pkg.sv */
// Shared types and constants for the bridge frame receive validator.
package bfrv_pkg;

	// Frame layout and limits.
	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] HDR_BYTES = 17'd12;
	localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;
	localparam logic [POS_W-1:0] POS_VERSION = 17'd4;
	localparam logic [POS_W-1:0] POS_SOURCE = 17'd5;
	localparam logic [POS_W-1:0] POS_DEST = 17'd6;
	localparam logic [POS_W-1:0] POS_LEN_LO = 17'd8;
	localparam logic [POS_W-1:0] POS_LEN_HI = 17'd9;
	localparam logic [POS_W-1:0] POS_SUM_LO = 17'd10;
	localparam logic [POS_W-1:0] POS_SUM_HI = 17'd11;
	localparam logic [POS_W-1:0] POS_MAGIC_END = 17'd4;
	localparam logic [31:0] FRAME_MAGIC = 32'h0047454F;
	localparam logic [7:0] FRAME_VERSION = 8'd1;

	// Configuration port.
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic REG_LOCAL_SUBNET = 1'b0;

	// Verdict codes, first failing check wins.
	typedef enum logic [2:0] {
		VERDICT_OK       = 3'd0,
		VERDICT_SHORT    = 3'd1,
		VERDICT_MAGIC    = 3'd2,
		VERDICT_VERSION  = 3'd3,
		VERDICT_LENGTH   = 3'd4,
		VERDICT_NOT_OURS = 3'd5,
		VERDICT_CHECKSUM = 3'd6
	} verdict_t;

	// One received byte.
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_item_t;

	// One frame verdict.
	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  source_subnet;
		logic [15:0] payload_length;
		logic [31:0] accepted_packets;
		logic [31:0] accepted_bytes;
	} out_item_t;

endpackage

/* rtl/core/bridge_frame_rx_validator.sv */
// Bridge frame receive validator: header capture, payload sum and verdict.
//
// Channel   Direction  Handshake             Carries
// in        to block   in_valid / in_ready   one frame byte and its last-byte mark
// out       from block out_valid / out_ready one verdict per frame, on the last byte
// config    to block   APB psel / penable    local_subnet at byte address 0
//
// A byte is registered on acceptance and judged in the next cycle; a verdict
// appears on out_valid once the judged last byte moves on into the result register.
// One byte is taken every clock unless the input stalls; the frame state register loop sets that rate.
// A waiting verdict stalls the input only when the next judged byte is also last.
// arst_n clears all frame state, both counters and local_subnet to zero.
module bridge_frame_rx_validator
	import bfrv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	// Input stage.
	logic     in_valid_s1;
	in_item_t in_s1;

	// Frame state.
	logic [POS_W-1:0] pos_q;
	logic [31:0]      magic_q;
	logic [7:0]       version_q;
	logic [7:0]       source_q;
	logic [7:0]       dest_q;
	logic [15:0]      len_q;
	logic [15:0]      sum_exp_q;
	logic [15:0]      run_sum_q;
	logic [31:0]      packet_total_q;
	logic [31:0]      byte_total_q;
	logic [7:0]       local_subnet_q;

	// Result stage.
	logic      out_valid_s2;
	out_item_t out_s2;

	// Next-state values.
	logic [POS_W-1:0] pos_next;
	logic [31:0]      magic_next;
	logic [7:0]       version_next;
	logic [7:0]       source_next;
	logic [7:0]       dest_next;
	logic [15:0]      len_next;
	logic [15:0]      sum_exp_next;
	logic [15:0]      run_sum_next;
	logic [16:0]      sum_raw;
	logic [POS_W-1:0] payload_end;
	logic             in_payload;
	verdict_t         verdict;
	logic             advance;
	logic             emit;
	logic             cfg_write;

	// The judged byte moves on unless it needs the result register while it is full.
	assign advance = in_valid_s1 && (!in_s1.last_byte || !out_valid_s2 || out_ready);
	assign emit = advance && in_s1.last_byte;
	assign in_ready = !in_valid_s1 || advance;

	// Payload window covers the bytes after the header up to the length field.
	assign payload_end = HDR_BYTES + {1'b0, len_q};
	assign in_payload = (pos_q >= HDR_BYTES) && (pos_q < payload_end);
	assign sum_raw = {1'b0, run_sum_q} + {9'd0, in_s1.frame_byte};

	// Take the byte into the header or the end-around-carry sum.
	always_comb begin
		magic_next = magic_q;
		version_next = version_q;
		source_next = source_q;
		dest_next = dest_q;
		len_next = len_q;
		sum_exp_next = sum_exp_q;
		run_sum_next = run_sum_q;
		if (pos_q < POS_MAGIC_END) begin
			magic_next[8*pos_q[1:0] +: 8] = in_s1.frame_byte;
		end else if (pos_q == POS_VERSION) begin
			version_next = in_s1.frame_byte;
		end else if (pos_q == POS_SOURCE) begin
			source_next = in_s1.frame_byte;
		end else if (pos_q == POS_DEST) begin
			dest_next = in_s1.frame_byte;
		end else if (pos_q == POS_LEN_LO) begin
			len_next[7:0] = in_s1.frame_byte;
		end else if (pos_q == POS_LEN_HI) begin
			len_next[15:8] = in_s1.frame_byte;
		end else if (pos_q == POS_SUM_LO) begin
			sum_exp_next[7:0] = in_s1.frame_byte;
		end else if (pos_q == POS_SUM_HI) begin
			sum_exp_next[15:8] = in_s1.frame_byte;
		end else if (in_payload) begin
			run_sum_next = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];
		end
		pos_next = (pos_q == POS_MAX) ? pos_q : (pos_q + 17'd1);
	end

	// Checks in priority order, on the state that includes this byte.
	always_comb begin
		if (pos_next < HDR_BYTES) begin
			verdict = VERDICT_SHORT;
		end else if (magic_next != FRAME_MAGIC) begin
			verdict = VERDICT_MAGIC;
		end else if (version_next != FRAME_VERSION) begin
			verdict = VERDICT_VERSION;
		end else if (pos_next < (HDR_BYTES + {1'b0, len_next})) begin
			verdict = VERDICT_LENGTH;
		end else if (dest_next != local_subnet_q) begin
			verdict = VERDICT_NOT_OURS;
		end else if (~run_sum_next != sum_exp_next) begin
			verdict = VERDICT_CHECKSUM;
		end else begin
			verdict = VERDICT_OK;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// Frame state and counters; the last byte clears the frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			magic_q <= '0;
			version_q <= '0;
			source_q <= '0;
			dest_q <= '0;
			len_q <= '0;
			sum_exp_q <= '0;
			run_sum_q <= '0;
			packet_total_q <= '0;
			byte_total_q <= '0;
		end else if (advance) begin
			if (in_s1.last_byte) begin
				pos_q <= '0;
				magic_q <= '0;
				version_q <= '0;
				source_q <= '0;
				dest_q <= '0;
				len_q <= '0;
				sum_exp_q <= '0;
				run_sum_q <= '0;
				if (verdict == VERDICT_OK) begin
					packet_total_q <= packet_total_q + 32'd1;
					byte_total_q <= byte_total_q + {16'd0, len_next};
				end
			end else begin
				pos_q <= pos_next;
				magic_q <= magic_next;
				version_q <= version_next;
				source_q <= source_next;
				dest_q <= dest_next;
				len_q <= len_next;
				sum_exp_q <= sum_exp_next;
				run_sum_q <= run_sum_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (emit) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_s2.verdict <= verdict;
			out_s2.source_subnet <= (verdict == VERDICT_SHORT) ? 8'd0 : source_next;
			out_s2.payload_length <= (verdict == VERDICT_SHORT) ? 16'd0 : len_next;
			out_s2.accepted_packets <= (verdict == VERDICT_OK) ?
				(packet_total_q + 32'd1) : packet_total_q;
			out_s2.accepted_bytes <= (verdict == VERDICT_OK) ?
				(byte_total_q + {16'd0, len_next}) : byte_total_q;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data = out_s2;

	// Configuration register, written in the access phase.
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_subnet_q <= '0;
		end else if (cfg_write && (paddr[2] == REG_LOCAL_SUBNET)) begin
			local_subnet_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_LOCAL_SUBNET) ? {24'd0, local_subnet_q} : 32'd0;

	// A new result only follows a judged last byte.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_s2) |-> $past(emit))
		else $error("result appeared without a judged last byte");

	// The frame state starts over after a last byte.
	a_pos_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (pos_q == '0) && (run_sum_q == '0))
		else $error("frame state not cleared after last byte");

	// The packet counter moves only for an accepted frame.
	a_count_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit && (verdict == VERDICT_OK)) |=> $stable(packet_total_q))
		else $error("packet counter moved without an accepted frame");

	// A short frame reports empty header fields.
	a_short_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && (out_s2.verdict == VERDICT_SHORT) |->
			(out_s2.source_subnet == 8'd0) && (out_s2.payload_length == 16'd0))
		else $error("short frame reports header fields");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !out_ready |=> $stable(out_s2))
		else $error("pending result overwritten");

endmodule

/* tb/bridge_frame_rx_validator_test.sv */
// Self-checking testbench for the bridge frame receive validator.
module bridge_frame_rx_validator_test;
	import bfrv_pkg::*;

	localparam int unsigned IDLE_PCT = 27;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RUN_LIMIT = 3000000;
	localparam int unsigned RANDOM_BYTES = 270;
	localparam int unsigned LONG_FRAME_KEEP = 40;
	localparam logic [CFG_ADDR_W-1:0] ADDR_LOCAL_SUBNET = {REG_LOCAL_SUBNET, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

	// Ways to spoil an otherwise good frame, combined as a bit mask.
	localparam int unsigned FLAW_NONE = 0;
	localparam int unsigned FLAW_MAGIC = 1;
	localparam int unsigned FLAW_VERSION = 2;
	localparam int unsigned FLAW_SUM = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Stimulus controls shared with the response side.
	logic send_gaps = 1'b0;
	logic recv_gaps = 1'b0;
	int unsigned hold_asked = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;

	int unsigned errors = 0;
	int unsigned bytes_accepted = 0;
	int unsigned verdicts_checked = 0;

	// Predicted frame state, configuration and counters.
	logic [7:0] node_subnet;
	logic [POS_W-1:0] rx_pos;
	logic [31:0] rx_magic;
	logic [7:0] rx_version;
	logic [7:0] rx_source;
	logic [7:0] rx_dest;
	logic [15:0] rx_len;
	logic [15:0] rx_sum_field;
	logic [15:0] rx_sum;
	logic [31:0] ok_frames;
	logic [31:0] ok_bytes;
	out_item_t pending_verdicts[$];
	out_item_t due;

	bridge_frame_rx_validator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// One's complement style byte add with end-around carry.
	function automatic logic [15:0] fold_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [16:0] s;
		s = {1'b0, acc} + {9'd0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic void clear_frame_state();
		rx_pos = '0;
		rx_magic = '0;
		rx_version = '0;
		rx_source = '0;
		rx_dest = '0;
		rx_len = '0;
		rx_sum_field = '0;
		rx_sum = '0;
	endfunction

	// Follows one accepted byte request and queues the verdict it closes, if any.
	function automatic void track_frame_byte(input logic [7:0] b, input logic l);
		int unsigned body_end;
		verdict_t v;
		out_item_t r;
		body_end = int'(HDR_BYTES) + int'(rx_len);
		if (rx_pos < POS_MAGIC_END)
			rx_magic[8*rx_pos[1:0] +: 8] = b;
		else if (rx_pos == POS_VERSION)
			rx_version = b;
		else if (rx_pos == POS_SOURCE)
			rx_source = b;
		else if (rx_pos == POS_DEST)
			rx_dest = b;
		else if (rx_pos == POS_LEN_LO)
			rx_len[7:0] = b;
		else if (rx_pos == POS_LEN_HI)
			rx_len[15:8] = b;
		else if (rx_pos == POS_SUM_LO)
			rx_sum_field[7:0] = b;
		else if (rx_pos == POS_SUM_HI)
			rx_sum_field[15:8] = b;
		else if (rx_pos >= HDR_BYTES && int'(rx_pos) < body_end)
			rx_sum = fold_byte(rx_sum, b);
		if (rx_pos != POS_MAX)
			rx_pos = rx_pos + 17'd1;
		if (!l)
			return;

		// The byte count now includes the last byte; first failing check wins.
		if (rx_pos < HDR_BYTES)
			v = VERDICT_SHORT;
		else if (rx_magic != FRAME_MAGIC)
			v = VERDICT_MAGIC;
		else if (rx_version != FRAME_VERSION)
			v = VERDICT_VERSION;
		else if (int'(rx_pos) < body_end)
			v = VERDICT_LENGTH;
		else if (rx_dest != node_subnet)
			v = VERDICT_NOT_OURS;
		else if (~rx_sum != rx_sum_field)
			v = VERDICT_CHECKSUM;
		else
			v = VERDICT_OK;
		if (v == VERDICT_OK) begin
			ok_frames = ok_frames + 1;
			ok_bytes = ok_bytes + {16'd0, rx_len};
		end
		r.verdict = v;
		r.source_subnet = (v == VERDICT_SHORT) ? 8'd0 : rx_source;
		r.payload_length = (v == VERDICT_SHORT) ? 16'd0 : rx_len;
		r.accepted_packets = ok_frames;
		r.accepted_bytes = ok_bytes;
		pending_verdicts.push_back(r);
		clear_frame_state();
	endfunction

	// Response side: random ready, or a long hold when a test asks for one.
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(recv_gaps && $urandom_range(99) < IDLE_PCT);
		end
	end

	// Compare each delivered verdict with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict delivered with none predicted");
				errors++;
			end else begin
				due = pending_verdicts.pop_front();
				verdicts_checked++;
				if (out_data.verdict !== due.verdict) begin
					$error("verdict: expected %0d, got %0d", due.verdict, out_data.verdict);
					errors++;
				end
				if (out_data.source_subnet !== due.source_subnet) begin
					$error("source_subnet: expected %0d, got %0d",
						due.source_subnet, out_data.source_subnet);
					errors++;
				end
				if (out_data.payload_length !== due.payload_length) begin
					$error("payload_length: expected %0d, got %0d",
						due.payload_length, out_data.payload_length);
					errors++;
				end
				if (out_data.accepted_packets !== due.accepted_packets) begin
					$error("accepted_packets: expected %0d, got %0d",
						due.accepted_packets, out_data.accepted_packets);
					errors++;
				end
				if (out_data.accepted_bytes !== due.accepted_bytes) begin
					$error("accepted_bytes: expected %0d, got %0d",
						due.accepted_bytes, out_data.accepted_bytes);
					errors++;
				end
			end
		end
	end

	// Offers one byte request, after random idle cycles, until accepted.
	task automatic push_byte(input logic [7:0] b, input logic l);
		while (send_gaps && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{frame_byte: b, last_byte: l};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_frame_byte(b, l);
		bytes_accepted++;
	endtask

	// Builds a frame with a correct checksum unless spoiled, then sends the first
	// keep bytes of it (all of them when keep is zero), marking the final one.
	task automatic send_frame(input logic [7:0] dest, input int unsigned plen,
			input int unsigned extra, input int unsigned flaws, input int unsigned keep);
		logic [7:0] payload[$];
		logic [7:0] frame[$];
		logic [15:0] acc;
		logic [15:0] len16;
		logic [15:0] sum_field;
		logic [31:0] magic;
		logic [7:0] version;
		logic [7:0] pb;
		int unsigned n;
		acc = '0;
		len16 = plen[15:0];
		magic = FRAME_MAGIC;
		version = FRAME_VERSION;
		for (int unsigned i = 0; i < plen; i++) begin
			pb = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255));
			payload.push_back(pb);
			acc = fold_byte(acc, pb);
		end
		sum_field = ~acc;
		if (flaws & FLAW_MAGIC)
			magic = magic ^ (32'h1 << $urandom_range(31));
		if (flaws & FLAW_VERSION) begin
			do
				version = 8'($urandom_range(255));
			while (version == FRAME_VERSION);
		end
		if (flaws & FLAW_SUM)
			sum_field = sum_field ^ 16'($urandom_range(1, 65535));
		for (int i = 0; i < 4; i++)
			frame.push_back(magic[8*i +: 8]);
		frame.push_back(version);
		frame.push_back(8'($urandom_range(255)));
		frame.push_back(dest);
		frame.push_back(8'($urandom_range(255)));
		frame.push_back(len16[7:0]);
		frame.push_back(len16[15:8]);
		frame.push_back(sum_field[7:0]);
		frame.push_back(sum_field[15:8]);
		frame = {frame, payload};
		for (int unsigned i = 0; i < extra; i++)
			frame.push_back(8'($urandom_range(255)));
		n = (keep != 0 && keep < frame.size()) ? keep : frame.size();
		for (int unsigned i = 0; i < n; i++)
			push_byte(frame[i], i == n - 1);
	endtask

	// Lets every predicted verdict arrive, then lets the pipeline settle.
	task automatic wait_for_verdicts();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_LOCAL_SUBNET)
			node_subnet = data[7:0];
	endtask

	task automatic apb_check_read(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[7:0] !== want) begin
			$error("local_subnet readback: expected %0d, got %0d", want, prdata[7:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_reset();
		node_subnet = '0;
		ok_frames = '0;
		ok_bytes = '0;
		clear_frame_state();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Each verdict in turn, a few in combination, and frames cut at header edges.
	task automatic test_header_checks();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		send_frame(8'h00, 0, 0, FLAW_NONE, 0);
		push_byte(8'($urandom_range(255)), 1'b1);
		send_frame(8'h00, 0, 0, FLAW_NONE, 11);
		send_frame(8'h00, 4, 0, FLAW_NONE, 9);
		send_frame(8'h00, 6, 0, FLAW_NONE, 0);
		send_frame(8'h00, 3, 0, FLAW_MAGIC, 0);
		send_frame(8'h00, 3, 0, FLAW_VERSION, 0);
		send_frame(8'h07, 3, 0, FLAW_MAGIC | FLAW_VERSION | FLAW_SUM, 0);
		send_frame(8'h00, 10, 0, FLAW_NONE, 15);
		send_frame(8'hFF, 10, 0, FLAW_SUM, 12);
		send_frame(8'h01, 2, 0, FLAW_NONE, 0);
		send_frame(8'hFF, 2, 0, FLAW_SUM, 0);
		send_frame(8'h00, 5, 0, FLAW_SUM, 0);
		send_frame(8'h00, 5, 3, FLAW_NONE, 0);
		send_frame(8'h00, 24, 0, FLAW_NONE, 0);
		wait_for_verdicts();
	endtask

	// Unmapped writes are dropped; the subnet register reads back what was written.
	task automatic test_register_map();
		apb_write(ADDR_UNMAPPED, 32'h0000_00A5);
		apb_check_read(ADDR_LOCAL_SUBNET, 8'h00);
		send_frame(8'h00, 2, 0, FLAW_NONE, 0);
		send_frame(8'hA5, 2, 0, FLAW_NONE, 0);
		wait_for_verdicts();
		apb_write(ADDR_LOCAL_SUBNET, 32'hFFFF_FF3C);
		apb_check_read(ADDR_LOCAL_SUBNET, 8'h3C);
		send_frame(8'h3C, 2, 0, FLAW_NONE, 0);
		send_frame(8'h00, 2, 0, FLAW_NONE, 0);
		wait_for_verdicts();
	endtask

	// Largest payload length the header can carry, in a frame cut well short of it.
	task automatic test_max_payload();
		send_gaps = 1'b0;
		send_frame(node_subnet, 65535, 0, FLAW_NONE, LONG_FRAME_KEEP);
		wait_for_verdicts();
	endtask

	// A long receiver hold while one-byte frames keep coming fills the block.
	task automatic test_output_stall();
		send_gaps = 1'b0;
		hold_asked++;
		for (int i = 0; i < 48; i++)
			push_byte(8'($urandom_range(255)), 1'b1);
		send_frame(node_subnet, 3, 0, FLAW_NONE, 0);
		send_frame(node_subnet, 0, 0, FLAW_NONE, 0);
		wait_for_verdicts();
	endtask

	// Mostly well-formed frames with random content, some spoiled, some noise.
	task automatic test_random_traffic(input logic [7:0] subnet, input logic gaps);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned plen;
		int unsigned extra;
		int unsigned count;
		logic [7:0] dest;
		apb_write(ADDR_LOCAL_SUBNET, {24'($urandom), subnet});
		send_gaps = gaps;
		recv_gaps = gaps;
		stop_at = bytes_accepted + RANDOM_BYTES;
		while (bytes_accepted < stop_at) begin
			pick = $urandom_range(99);
			plen = ($urandom_range(19) == 0) ? $urandom_range(17, 400) : $urandom_range(0, 16);
			extra = ($urandom_range(4) == 0) ? $urandom_range(1, 5) : 0;
			dest = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : node_subnet;
			if (pick < 60) begin
				send_frame(dest, plen, extra, FLAW_NONE, 0);
			end else if (pick < 80) begin
				send_frame(dest, plen, extra, $urandom_range(1, 7), 0);
			end else if (pick < 90) begin
				send_frame(dest, plen, extra, FLAW_NONE, $urandom_range(1, 11 + plen));
			end else begin
				count = $urandom_range(1, 24);
				for (int unsigned i = 0; i < count; i++)
					push_byte(8'($urandom_range(255)),
						i == count - 1 || $urandom_range(9) == 0);
			end
		end
		wait_for_verdicts();
	endtask

	initial begin
		apply_reset();
		test_header_checks();
		test_register_map();
		test_max_payload();
		test_output_stall();
		test_random_traffic(8'hFF, 1'b1);
		test_random_traffic(8'($urandom_range(255)), 1'b0);
		test_random_traffic(8'h00, 1'b1);
		test_random_traffic(8'($urandom_range(255)), 1'b1);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d verdicts (%0d frames accepted) over %0d bytes,",
			verdicts_checked, ok_frames, bytes_accepted);
		$display("covering every verdict, output holds and several local subnet values.");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#RUN_LIMIT;
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* bridge_frame_rx_validator.f */
rtl/core/bfrv_pkg.sv
rtl/core/bridge_frame_rx_validator.sv
tb/bridge_frame_rx_validator_test.sv
